// ===== hw/rtl/aebd_pkg.sv =====
// ----------------------------------------------------------------------------
// aebd_pkg
// Shared constants, types and position helpers for the elastic audio buffer.
// ----------------------------------------------------------------------------
package aebd_pkg;

  localparam int unsigned SEG_WORDS  = 32;
  localparam int unsigned NUM_SEGS   = 8;
  localparam int unsigned RING_WORDS = SEG_WORDS * NUM_SEGS;

  localparam int unsigned SEG_W      = $clog2(NUM_SEGS);
  localparam int unsigned OFF_W      = $clog2(SEG_WORDS);
  localparam int unsigned ADDR_W     = SEG_W + OFF_W;
  localparam int unsigned MEM_DEPTH  = NUM_SEGS * (2 ** OFF_W);
  localparam int unsigned DIST_W     = $clog2(NUM_SEGS + 1);
  localparam int unsigned HALF_SEGS  = NUM_SEGS / 2;

  localparam int unsigned HALF_RING  = RING_WORDS / 2;
  localparam int unsigned HALF_SEG   = HALF_RING / SEG_WORDS;
  localparam int unsigned HALF_OFF   = HALF_RING % SEG_WORDS;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned WORD_IDX_W = 6;
  localparam int unsigned IDLE_W     = 2;
  localparam logic [IDLE_W-1:0] IDLE_MAX = 2'd3;

  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_WORD = 2'd0,
    OP_REQ  = 2'd1,
    OP_MUTE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    K_WORD,
    K_REQ,
    K_MUTE
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUP_A,
    S_DUP_B,
    S_DUP_C,
    S_REQ
  } state_e;

  typedef struct packed {
    kind_e                kind;
    logic [SAMPLE_W-1:0]  sample;
    logic                 last;
    logic                 half;
    logic                 mute;
  } cmd_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [OFF_W-1:0] off;
  } pos_t;

  localparam pos_t HALF_POS = '{seg: SEG_W'(HALF_SEG), off: OFF_W'(HALF_OFF)};

  function automatic pos_t pos_inc(pos_t p);
    pos_t r;
    r = p;
    if (p.off == OFF_W'(SEG_WORDS - 1)) begin
      r.off = '0;
      r.seg = (p.seg == SEG_W'(NUM_SEGS - 1)) ? '0 : p.seg + SEG_W'(1);
    end else begin
      r.off = p.off + OFF_W'(1);
    end
    return r;
  endfunction

  function automatic pos_t pos_dec(pos_t p);
    pos_t r;
    r = p;
    if (p.off == '0) begin
      r.off = OFF_W'(SEG_WORDS - 1);
      r.seg = (p.seg == '0) ? SEG_W'(NUM_SEGS - 1) : p.seg - SEG_W'(1);
    end else begin
      r.off = p.off - OFF_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/aebd_front.sv =====
// ----------------------------------------------------------------------------
// aebd_front
// Input register: accepts items, classifies the op and hands commands on.
// ----------------------------------------------------------------------------
module aebd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [aebd_pkg::OP_W-1:0]      op_i,
  input  logic [aebd_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                           packet_last_i,
  input  logic                           target_half_i,
  input  logic                           mute_on_i,
  output logic                           push_o,
  output aebd_pkg::cmd_t                 push_cmd_o,
  input  logic                           q_full_i
);

  logic           f_valid_q, f_valid_d;
  aebd_pkg::cmd_t f_cmd_q, f_cmd_d;
  logic           in_acc;
  logic           op_ok;
  aebd_pkg::kind_e kind;

  assign in_stall_o = f_valid_q && q_full_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign push_o     = f_valid_q && !q_full_i;
  assign push_cmd_o = f_cmd_q;

  always_comb begin
    op_ok = 1'b1;
    kind  = aebd_pkg::K_WORD;
    case (op_i)
      aebd_pkg::OP_WORD: kind = aebd_pkg::K_WORD;
      aebd_pkg::OP_REQ:  kind = aebd_pkg::K_REQ;
      aebd_pkg::OP_MUTE: kind = aebd_pkg::K_MUTE;
      default:           op_ok = 1'b0;
    endcase
  end

  always_comb begin
    f_valid_d = (f_valid_q && q_full_i) || (in_acc && op_ok);
    f_cmd_d   = f_cmd_q;
    if (in_acc) begin
      f_cmd_d.kind   = kind;
      f_cmd_d.sample = sample_i;
      f_cmd_d.last   = packet_last_i;
      f_cmd_d.half   = target_half_i;
      f_cmd_d.mute   = mute_on_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_cmd_q <= f_cmd_d;
  end

endmodule

// ===== hw/rtl/aebd_queue.sv =====
// ----------------------------------------------------------------------------
// aebd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module aebd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  aebd_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output aebd_pkg::cmd_t head_o,
  output logic           empty_o
);

  aebd_pkg::cmd_t                   store_q [aebd_pkg::Q_DEPTH];
  logic [aebd_pkg::Q_PTR_W-1:0]     wr_q, wr_d;
  logic [aebd_pkg::Q_PTR_W-1:0]     rd_q, rd_d;
  logic [aebd_pkg::Q_CNT_W-1:0]     cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == aebd_pkg::Q_CNT_W'(aebd_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = store_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + aebd_pkg::Q_PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + aebd_pkg::Q_PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + aebd_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - aebd_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hw/rtl/aebd_back.sv =====
// ----------------------------------------------------------------------------
// aebd_back
// Execution engine: ring memory, drift slip, segment playback, output stage.
// ----------------------------------------------------------------------------
module aebd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  aebd_pkg::cmd_t                    q_head_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [aebd_pkg::SAMPLE_W-1:0]     out_sample_o,
  output logic                              out_half_o,
  output logic [aebd_pkg::WORD_IDX_W-1:0]   word_index_o,
  output logic                              seg_last_o,
  output logic                              muted_o
);

  aebd_pkg::state_e                 state_q, state_d;
  aebd_pkg::pos_t                   wp_q, wp_d;
  logic [aebd_pkg::SEG_W-1:0]       rs_q, rs_d;
  logic [aebd_pkg::DIST_W-1:0]      dist_q, dist_d;
  logic                             first_q, first_d;
  logic [aebd_pkg::IDLE_W-1:0]      idle_q, idle_d;
  logic                             soft_q, soft_d;
  logic                             hard_q, hard_d;

  logic [aebd_pkg::SEG_W-1:0]       req_seg_q, req_seg_d;
  logic                             req_zero_q, req_zero_d;
  logic                             req_muted_q, req_muted_d;
  logic                             req_half_q, req_half_d;
  logic                             req_clr_q, req_clr_d;
  logic [aebd_pkg::OFF_W-1:0]       idx_q, idx_d;

  logic                             out_valid_q, out_valid_d;
  logic                             out_zero_q, out_zero_d;
  logic                             out_half_q, out_half_d;
  logic [aebd_pkg::OFF_W-1:0]       out_idx_q, out_idx_d;
  logic                             out_last_q, out_last_d;
  logic                             out_muted_q, out_muted_d;

  logic [aebd_pkg::SAMPLE_W-1:0]    mem [aebd_pkg::MEM_DEPTH];
  logic [aebd_pkg::MEM_DEPTH-1:0]   vld_q, vld_d;
  logic [aebd_pkg::SAMPLE_W-1:0]    rdata_q;
  logic                             rvld_q;

  logic                             mem_we, mem_re, ring_clr;
  logic [aebd_pkg::ADDR_W-1:0]      waddr, raddr;
  logic [aebd_pkg::SAMPLE_W-1:0]    wdata, rword;

  logic                             out_free, head_last, pop_ok, issue, idx_end;
  aebd_pkg::pos_t                   wp_inc;
  logic [aebd_pkg::DIST_W-1:0]      seg_dist, rs_ext, us_ext;
  logic                             dup_go, drop_go, was_muted, timeout;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign head_last = (q_head_i.kind == aebd_pkg::K_WORD) && q_head_i.last;
  assign pop_ok    = (state_q == aebd_pkg::S_IDLE) && !q_empty_i && (!head_last || out_free);
  assign issue     = (state_q == aebd_pkg::S_REQ) && out_free;
  assign idx_end   = (idx_q == aebd_pkg::OFF_W'(aebd_pkg::SEG_WORDS - 1));
  assign rword     = rvld_q ? rdata_q : '0;

  // segment distance from the write segment to the read segment
  assign wp_inc   = aebd_pkg::pos_inc(wp_q);
  assign rs_ext   = aebd_pkg::DIST_W'(rs_q);
  assign us_ext   = aebd_pkg::DIST_W'(wp_inc.seg);
  assign seg_dist = (rs_ext > us_ext) ? rs_ext - us_ext
                  : rs_ext + aebd_pkg::DIST_W'(aebd_pkg::NUM_SEGS) - us_ext;
  assign dup_go   = !first_q && (dist_q < seg_dist)
                  && (seg_dist > aebd_pkg::DIST_W'(aebd_pkg::HALF_SEGS));
  assign drop_go  = !first_q && (dist_q > seg_dist)
                  && (seg_dist < aebd_pkg::DIST_W'(aebd_pkg::HALF_SEGS));

  assign was_muted = soft_q || hard_q;
  assign timeout   = !was_muted && (idle_q >= aebd_pkg::IDLE_W'(2));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      aebd_pkg::S_IDLE: begin
        if (pop_ok) begin
          if (q_head_i.kind == aebd_pkg::K_REQ) begin
            state_d = aebd_pkg::S_REQ;
          end else if (head_last && dup_go) begin
            state_d = aebd_pkg::S_DUP_A;
          end
        end
      end
      aebd_pkg::S_DUP_A: state_d = aebd_pkg::S_DUP_B;
      aebd_pkg::S_DUP_B: state_d = aebd_pkg::S_DUP_C;
      aebd_pkg::S_DUP_C: state_d = aebd_pkg::S_IDLE;
      aebd_pkg::S_REQ: begin
        if (issue && idx_end) begin
          state_d = aebd_pkg::S_IDLE;
        end
      end
      default: state_d = aebd_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    ring_clr    = 1'b0;
    waddr       = wp_q;
    raddr       = wp_q;
    wdata       = rword;
    wp_d        = wp_q;
    rs_d        = rs_q;
    dist_d      = dist_q;
    first_d     = first_q;
    idle_d      = idle_q;
    soft_d      = soft_q;
    hard_d      = hard_q;
    req_seg_d   = req_seg_q;
    req_zero_d  = req_zero_q;
    req_muted_d = req_muted_q;
    req_half_d  = req_half_q;
    req_clr_d   = req_clr_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_zero_d  = out_zero_q;
    out_half_d  = out_half_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_muted_d = out_muted_q;

    case (state_q)
      aebd_pkg::S_IDLE: begin
        if (pop_ok) begin
          q_pop_o = 1'b1;
          case (q_head_i.kind)
            aebd_pkg::K_WORD: begin
              mem_we = 1'b1;
              waddr  = wp_q;
              wdata  = q_head_i.sample;
              idle_d = '0;
              soft_d = 1'b0;
              wp_d   = wp_inc;
              if (q_head_i.last) begin
                dist_d  = seg_dist;
                first_d = 1'b0;
                if (drop_go) begin
                  wp_d = aebd_pkg::pos_dec(aebd_pkg::pos_dec(wp_inc));
                end
              end
            end
            aebd_pkg::K_REQ: begin
              req_seg_d  = rs_q;
              req_zero_d = was_muted;
              req_half_d = q_head_i.half;
              req_clr_d  = 1'b0;
              idx_d      = '0;
              if (!was_muted) begin
                rs_d   = (rs_q == aebd_pkg::SEG_W'(aebd_pkg::NUM_SEGS - 1))
                       ? '0 : rs_q + aebd_pkg::SEG_W'(1);
                idle_d = (idle_q == aebd_pkg::IDLE_MAX) ? idle_q
                       : idle_q + aebd_pkg::IDLE_W'(1);
                if (timeout) begin
                  soft_d    = 1'b1;
                  rs_d      = '0;
                  wp_d      = aebd_pkg::HALF_POS;
                  idle_d    = aebd_pkg::IDLE_MAX;
                  req_clr_d = 1'b1;
                end
              end
              req_muted_d = timeout || was_muted;
            end
            aebd_pkg::K_MUTE: begin
              hard_d = q_head_i.mute;
            end
            default: ;
          endcase
        end
      end
      aebd_pkg::S_DUP_A: begin
        mem_re = 1'b1;
        raddr  = aebd_pkg::pos_dec(aebd_pkg::pos_dec(wp_q));
      end
      aebd_pkg::S_DUP_B: begin
        mem_re = 1'b1;
        raddr  = aebd_pkg::pos_dec(wp_q);
        mem_we = 1'b1;
        waddr  = wp_q;
        wdata  = rword;
      end
      aebd_pkg::S_DUP_C: begin
        mem_we = 1'b1;
        waddr  = wp_inc;
        wdata  = rword;
        wp_d   = aebd_pkg::pos_inc(wp_inc);
      end
      aebd_pkg::S_REQ: begin
        if (issue) begin
          mem_re      = 1'b1;
          raddr       = {req_seg_q, idx_q};
          out_valid_d = 1'b1;
          out_zero_d  = req_zero_q;
          out_half_d  = req_half_q;
          out_idx_d   = idx_q;
          out_last_d  = idx_end;
          out_muted_d = req_muted_q;
          idx_d       = idx_q + aebd_pkg::OFF_W'(1);
          ring_clr    = idx_end && req_clr_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (mem_we) begin
      vld_d[waddr] = 1'b1;
    end
    if (ring_clr) begin
      vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aebd_pkg::S_IDLE;
      wp_q        <= '0;
      rs_q        <= '0;
      dist_q      <= '0;
      first_q     <= 1'b1;
      idle_q      <= '0;
      soft_q      <= 1'b0;
      hard_q      <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rs_q        <= rs_d;
      dist_q      <= dist_d;
      first_q     <= first_d;
      idle_q      <= idle_d;
      soft_q      <= soft_d;
      hard_q      <= hard_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
      if (mem_re) begin
        rvld_q <= vld_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_seg_q   <= req_seg_d;
    req_zero_q  <= req_zero_d;
    req_muted_q <= req_muted_d;
    req_half_q  <= req_half_d;
    req_clr_q   <= req_clr_d;
    idx_q       <= idx_d;
    out_zero_q  <= out_zero_d;
    out_half_q  <= out_half_d;
    out_idx_q   <= out_idx_d;
    out_last_q  <= out_last_d;
    out_muted_q <= out_muted_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_zero_q ? '0 : rword;
  assign out_half_o   = out_half_q;
  assign word_index_o = aebd_pkg::WORD_IDX_W'(out_idx_q);
  assign seg_last_o   = out_last_q;
  assign muted_o      = out_muted_q;

  // read data is shared between slip and playback
  a_dup_no_pending_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aebd_pkg::S_DUP_A) |-> !out_valid_q)
    else $error("frame slip started with a word still in the output stage");

  a_clear_not_with_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_clr |-> !mem_we)
    else $error("ring clear collides with a write");

  a_wp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q.seg < aebd_pkg::SEG_W'(aebd_pkg::NUM_SEGS - 1) ||
     wp_q.seg == aebd_pkg::SEG_W'(aebd_pkg::NUM_SEGS - 1)) &&
    (wp_q.off < aebd_pkg::OFF_W'(aebd_pkg::SEG_WORDS - 1) ||
     wp_q.off == aebd_pkg::OFF_W'(aebd_pkg::SEG_WORDS - 1)))
    else $error("write position outside the ring");

  a_dup_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aebd_pkg::S_DUP_A) |=> (state_q == aebd_pkg::S_DUP_B))
    else $error("frame slip sequence broken");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == aebd_pkg::S_IDLE) && !q_empty_i)
    else $error("command taken while busy or queue empty");

endmodule

// ===== hw/rtl/audio_elastic_buffer_drift_adjust.sv =====
// ----------------------------------------------------------------------------
// audio_elastic_buffer_drift_adjust
// Elastic audio ring with stereo frame slip between packet writer and player.
// ----------------------------------------------------------------------------
// input channel: one item per handshake (packet word, segment request or
// hardware mute change); op 3 is taken and ignored. items pass an input
// register and a four-entry command queue before the engine executes them.
// packet word: executed in S_IDLE; a packet end that duplicates the last
// stereo frame then runs S_DUP_A, S_DUP_B and S_DUP_C (two reads and two writes
// on the ring memory, which has one read port and one write port with
// registered read data). mute change: handled in S_IDLE.
// segment request: first word reaches the output register through the input
// register, the queue and state S_REQ, then one word per cycle unless the
// receiver stalls, SEG_WORDS words in all; the one ring read port sets the rate.
// output channel: a single output register; while the receiver stalls it
// holds its word, the request pauses, the queue fills and in_stall_o rises.
// reset: ring reads as zero through per-word valid bits, so no clearing pass
// is needed; the idle timeout clears all those bits with its last request word.
// ----------------------------------------------------------------------------
module audio_elastic_buffer_drift_adjust (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [aebd_pkg::OP_W-1:0]         op_i,
  input  logic [aebd_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                              packet_last_i,
  input  logic                              target_half_i,
  input  logic                              mute_on_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [aebd_pkg::SAMPLE_W-1:0]     out_sample_o,
  output logic                              out_half_o,
  output logic [aebd_pkg::WORD_IDX_W-1:0]   word_index_o,
  output logic                              seg_last_o,
  output logic                              muted_o
);

  logic           push, q_full, q_empty, q_pop;
  aebd_pkg::cmd_t push_cmd, q_head;

  aebd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .sample_i      (sample_i),
    .packet_last_i (packet_last_i),
    .target_half_i (target_half_i),
    .mute_on_i     (mute_on_i),
    .push_o        (push),
    .push_cmd_o    (push_cmd),
    .q_full_i      (q_full)
  );

  aebd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  aebd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_sample_o (out_sample_o),
    .out_half_o   (out_half_o),
    .word_index_o (word_index_o),
    .seg_last_o   (seg_last_o),
    .muted_o      (muted_o)
  );

endmodule

// ===== tb/sv/aebd_ring_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aebd_ring_checker
// Watches both channels of the elastic audio buffer, keeps its own copy of
// the ring, write position, read segment, distance and mute state, predicts
// the playback words of every accepted request and compares each delivered
// word with the oldest prediction.
// ----------------------------------------------------------------------------
module aebd_ring_checker
  import aebd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [OP_W-1:0]       op_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic                  packet_last_i,
  input  logic                  target_half_i,
  input  logic                  mute_on_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [SAMPLE_W-1:0]   out_sample_i,
  input  logic                  out_half_i,
  input  logic [WORD_IDX_W-1:0] word_index_i,
  input  logic                  seg_last_i,
  input  logic                  muted_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    frame_dups_o,
  output int                    frame_drops_o,
  output int                    idle_timeouts_o
);

  typedef struct packed {
    logic [SAMPLE_W-1:0]   sample;
    logic                  half;
    logic [WORD_IDX_W-1:0] idx;
    logic                  seg_last;
    logic                  muted;
  } playback_word_t;

  playback_word_t      playback_q[$];
  logic [SAMPLE_W-1:0] ring_mem [RING_WORDS];
  logic [ADDR_W-1:0]   wr_pos;
  logic [SEG_W-1:0]    rd_seg;
  logic [DIST_W-1:0]   dist_now;
  logic [DIST_W-1:0]   dist_prev;
  logic                first_pkt;
  logic [IDLE_W-1:0]   idle_reqs;
  logic                soft_mute;
  logic                hard_mute;

  function automatic logic [ADDR_W-1:0] ring_wrap(int unsigned p);
    return ADDR_W'(p % RING_WORDS);
  endfunction

  task automatic clear_ring();
    for (int i = 0; i < RING_WORDS; i++) ring_mem[i] = '0;
  endtask

  // distance measure and stereo frame slip at the end of a packet
  task automatic close_packet();
    int unsigned         usb_seg;
    logic [DIST_W-1:0]   d;
    logic [SAMPLE_W-1:0] frame_l;
    logic [SAMPLE_W-1:0] frame_r;
    usb_seg = wr_pos / SEG_WORDS;
    if (rd_seg > usb_seg) d = DIST_W'(rd_seg - usb_seg);
    else d = DIST_W'(rd_seg + NUM_SEGS - usb_seg);
    if (first_pkt) begin
      dist_now  = d;
      dist_prev = d;
      first_pkt = 1'b0;
    end else begin
      dist_prev = dist_now;
      dist_now  = d;
      if (dist_prev < d && d > HALF_SEGS) begin
        frame_l = ring_mem[ring_wrap(wr_pos + RING_WORDS - 2)];
        frame_r = ring_mem[ring_wrap(wr_pos + RING_WORDS - 1)];
        ring_mem[ring_wrap(wr_pos)]     = frame_l;
        ring_mem[ring_wrap(wr_pos + 1)] = frame_r;
        wr_pos = ring_wrap(wr_pos + 2);
        frame_dups_o++;
      end else if (dist_prev > d && d < HALF_SEGS) begin
        wr_pos = ring_wrap(wr_pos + RING_WORDS - 2);
        frame_drops_o++;
      end
    end
  endtask

  task automatic serve_request(logic half);
    logic                was_muted;
    int unsigned         base;
    logic [SAMPLE_W-1:0] seg_words [SEG_WORDS];
    playback_word_t      w;
    was_muted = soft_mute | hard_mute;
    base = rd_seg * SEG_WORDS;
    for (int i = 0; i < SEG_WORDS; i++) begin
      seg_words[i] = was_muted ? '0 : ring_mem[ring_wrap(base + i)];
    end
    if (!was_muted) begin
      rd_seg = SEG_W'((rd_seg + 1) % NUM_SEGS);
      if (idle_reqs < IDLE_MAX) idle_reqs++;
      // idle timeout
      if (idle_reqs == IDLE_MAX && !soft_mute) begin
        soft_mute = 1'b1;
        rd_seg    = '0;
        wr_pos    = ADDR_W'(HALF_RING);
        clear_ring();
        idle_timeouts_o++;
      end
    end
    for (int i = 0; i < SEG_WORDS; i++) begin
      w.sample   = seg_words[i];
      w.half     = half;
      w.idx      = WORD_IDX_W'(i);
      w.seg_last = (i == SEG_WORDS - 1);
      w.muted    = soft_mute | hard_mute;
      playback_q.push_back(w);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    playback_word_t got;
    playback_word_t exp_word;
    if (!rst_ni) begin
      playback_q.delete();
      clear_ring();
      wr_pos          = '0;
      rd_seg          = '0;
      dist_now        = '0;
      dist_prev       = '0;
      first_pkt       = 1'b1;
      idle_reqs       = '0;
      soft_mute       = 1'b0;
      hard_mute       = 1'b0;
      fail_count_o    = 0;
      checked_o       = 0;
      frame_dups_o    = 0;
      frame_drops_o   = 0;
      idle_timeouts_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        case (op_i)
          OP_WORD: begin
            idle_reqs = '0;
            soft_mute = 1'b0;
            ring_mem[wr_pos] = sample_i;
            wr_pos = ring_wrap(wr_pos + 1);
            if (packet_last_i) close_packet();
          end
          OP_REQ:  serve_request(target_half_i);
          OP_MUTE: hard_mute = mute_on_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{sample: out_sample_i, half: out_half_i, idx: word_index_i,
                seg_last: seg_last_i, muted: muted_i};
        if (playback_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected playback word, expected none", $time);
          $display("  actual   sample %h half %b index %0d last %b muted %b",
                   got.sample, got.half, got.idx, got.seg_last, got.muted);
        end else begin
          exp_word = playback_q.pop_front();
          checked_o++;
          if (got !== exp_word) begin
            fail_count_o++;
            $display("%0t: playback word mismatch", $time);
            $display("  expected sample %h half %b index %0d last %b muted %b",
                     exp_word.sample, exp_word.half, exp_word.idx, exp_word.seg_last,
                     exp_word.muted);
            $display("  actual   sample %h half %b index %0d last %b muted %b",
                     got.sample, got.half, got.idx, got.seg_last, got.muted);
          end
        end
      end
    end
    pending_o = playback_q.size();
  end

endmodule

// ===== tb/sv/tb_audio_elastic_buffer_drift_adjust.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_audio_elastic_buffer_drift_adjust
// Drives packet words, segment requests and mute changes into the elastic
// audio buffer with bursty input and a stalling receiver, including a long
// receiver hold-off and a full drain pause; a checker beside the block
// predicts and compares every playback word.
// ----------------------------------------------------------------------------
module tb_audio_elastic_buffer_drift_adjust;
  import aebd_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned ITEM_TARGET    = 170;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_SPARSE} rx_mode_e;
  typedef enum logic [2:0] {
    RND_PACKET, RND_REQ, RND_MUTE, RND_NOISE, RND_PARTIAL
  } round_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic [OP_W-1:0]       in_op     = OP_WORD;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  in_last   = 1'b0;
  logic                  in_half   = 1'b0;
  logic                  in_mute   = 1'b0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [SAMPLE_W-1:0]   out_sample;
  logic                  out_half;
  logic [WORD_IDX_W-1:0] word_index;
  logic                  seg_last;
  logic                  muted;

  int fail_count;
  int pending;
  int checked;
  int frame_dups;
  int frame_drops;
  int idle_timeouts;
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;

  always #2 clk = ~clk;

  audio_elastic_buffer_drift_adjust i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (in_op),
    .sample_i      (in_sample),
    .packet_last_i (in_last),
    .target_half_i (in_half),
    .mute_on_i     (in_mute),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_sample_o  (out_sample),
    .out_half_o    (out_half),
    .word_index_o  (word_index),
    .seg_last_o    (seg_last),
    .muted_o       (muted)
  );

  aebd_ring_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .op_i            (in_op),
    .sample_i        (in_sample),
    .packet_last_i   (in_last),
    .target_half_i   (in_half),
    .mute_on_i       (in_mute),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_sample_i    (out_sample),
    .out_half_i      (out_half),
    .word_index_i    (word_index),
    .seg_last_i      (seg_last),
    .muted_i         (muted),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .frame_dups_o    (frame_dups),
    .frame_drops_o   (frame_drops),
    .idle_timeouts_o (idle_timeouts)
  );

  task automatic push_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp, logic last,
                           logic half, logic mute);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_op     <= op;
    in_sample <= smp;
    in_last   <= last;
    in_half   <= half;
    in_mute   <= mute;
    do @(posedge clk); while (in_stall);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_packet(int unsigned len, bit closed);
    logic [SAMPLE_W-1:0] smp;
    for (int unsigned k = 0; k < len; k++) begin
      case ($urandom_range(0, 7))
        0:       smp = '0;
        1:       smp = '1;
        default: smp = $urandom;
      endcase
      push_item(OP_WORD, smp, closed && (k == len - 1), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    bit          hold_done;
    mode      = RX_FREE;
    mode_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
          default:   out_stall <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    round_e      rnd;
    int unsigned pick;
    logic        hw_mute;
    hw_mute = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first packet only records the distance
    push_item(OP_WORD, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    push_item(OP_WORD, 32'h0000_0000, 1'b0, 1'b1, 1'b1);
    push_item(OP_WORD, 32'h5A5A_A5A5, 1'b1, 1'b0, 1'b0);
    // request under hardware mute
    push_item(OP_MUTE, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
    push_item(OP_REQ,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    push_item(OP_UNUSED, $urandom, 1'b1, 1'b1, 1'b1);
    push_item(OP_MUTE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    // four requests without packet words: idle timeout on the third
    push_item(OP_REQ, $urandom, 1'b0, 1'b0, 1'b1);
    push_item(OP_REQ, $urandom, 1'b1, 1'b1, 1'b0);
    push_item(OP_REQ, $urandom, 1'b0, 1'b0, 1'b0);
    push_item(OP_REQ, $urandom, 1'b0, 1'b1, 1'b1);
    // packet word while soft muted, then a growing distance
    push_item(OP_WORD, 32'h1234_5678, 1'b1, 1'b0, 1'b0);
    push_item(OP_REQ,  $urandom, 1'b1, 1'b0, 1'b1);
    push_item(OP_WORD, 32'h8000_0001, 1'b1, 1'b1, 1'b0);
    push_item(OP_MUTE, $urandom, 1'b0, 1'b0, 1'b1);
    push_item(OP_WORD, 32'h7FFF_FFFE, 1'b0, 1'b1, 1'b0);
    push_item(OP_REQ,  $urandom, 1'b0, 1'b1, 1'b0);
    push_item(OP_MUTE, $urandom, 1'b1, 1'b0, 1'b0);
    push_item(OP_REQ,  $urandom, 1'b1, 1'b0, 1'b1);

    // drain pause
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);

    // long receiver hold while items keep coming
    hold_req = 1'b1;
    push_item(OP_REQ, $urandom, 1'b0, 1'b1, 1'b0);
    push_item(OP_REQ, $urandom, 1'b0, 1'b0, 1'b0);
    send_packet(10, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) rnd = RND_PACKET;
      else if (pick < 85) rnd = RND_REQ;
      else if (pick < 91) rnd = RND_MUTE;
      else if (pick < 95) rnd = RND_NOISE;
      else rnd = RND_PARTIAL;
      case (rnd)
        RND_PACKET: send_packet(($urandom_range(0, 4) == 0) ? $urandom_range(17, 40)
                                                             : $urandom_range(1, 12), 1'b1);
        RND_REQ: begin
          repeat ($urandom_range(1, 2))
            push_item(OP_REQ, $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        RND_MUTE: begin
          hw_mute = hw_mute ? 1'b0 : 1'($urandom_range(0, 1));
          push_item(OP_MUTE, $urandom, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), hw_mute);
        end
        RND_NOISE: push_item(OP_UNUSED, $urandom, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: send_packet($urandom_range(1, 6), 1'b0);
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d items sent, %0d playback words checked, long hold and drain pause done",
             items_sent, checked);
    $display("tb: %0d frame repeats, %0d frame drops, %0d idle timeouts",
             frame_dups, frame_drops, idle_timeouts);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
